// ===== rtl/mmss_pkg.sv =====
// ----------------------------------------------------------------------------
// mmss_pkg
// Shared types, codes and helper functions for the MM:SS frame builder.
// ----------------------------------------------------------------------------
package mmss_pkg;

    // Command codes carried on s_tuser
    localparam logic [1:0] OP_TIME  = 2'd0;
    localparam logic [1:0] OP_BLANK = 2'd1;
    localparam logic [1:0] OP_DONE  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_SLOT_A_HIGH = 3'd0;
    localparam logic [2:0] CFG_SLOT_A_LOW  = 3'd1;
    localparam logic [2:0] CFG_SLOT_B_HIGH = 3'd2;
    localparam logic [2:0] CFG_SLOT_B_LOW  = 3'd3;
    localparam logic [2:0] CFG_COLON_POS   = 3'd4;

    // Divisors for the two division passes
    localparam logic [15:0] MS_PER_MIN = 16'd60000;
    localparam logic [15:0] MS_PER_SEC = 16'd1000;
    localparam logic [31:0] MIN_CLAMP  = 32'd99;

    // Glyphs for the word dOnE (bit0 = A .. bit6 = G)
    localparam logic [6:0] GLYPH_LOWER_D = 7'h5E;
    localparam logic [6:0] GLYPH_UPPER_O = 7'h3F;
    localparam logic [6:0] GLYPH_LOWER_N = 7'h54;
    localparam logic [6:0] GLYPH_UPPER_E = 7'h79;

    // Configuration register set
    typedef struct packed {
        logic [1:0] slot_a_high;
        logic [1:0] slot_a_low;
        logic [1:0] slot_b_high;
        logic [1:0] slot_b_low;
        logic [3:0] colon_pos;
    } cfg_t;

    // Decimal digit to segment pattern
    function automatic logic [6:0] font_digit(input logic [3:0] d);
        logic [6:0] seg;
        case (d)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

    // Tens digit of a value below 100: multiply by 205, take bits 14..11
    function automatic logic [3:0] tens_of(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd205;
        return p[14:11];
    endfunction

    // Units digit of a value below 100
    function automatic logic [3:0] units_of(input logic [6:0] x);
        logic [6:0] r;
        r = x - 7'(tens_of(x)) * 7'd10;
        return r[3:0];
    endfunction

endpackage

// ===== rtl/mmss_div.sv =====
// ----------------------------------------------------------------------------
// mmss_div
// Bit-serial restoring divider: 32-bit dividend by 16-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mmss_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg,  cnt_next;
    logic [31:0] quo_reg,  quo_next;
    logic [15:0] rem_reg,  rem_next;
    logic [15:0] d_reg,    d_next;
    logic [16:0] trial;
    logic        fits;

    // One restoring step: bring down the next dividend bit and try a subtract
    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = trial >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            quo_next  = dividend;
            rem_next  = 16'd0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], fits};
            rem_next = fits ? 16'(trial - {1'b0, d_reg}) : trial[15:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // Partial remainder stays below the divisor throughout a division
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < d_reg)
        else $error("divider remainder not below divisor");

endmodule

// ===== rtl/mmss_pack.sv =====
// ----------------------------------------------------------------------------
// mmss_pack
// Splits minutes and seconds into digits, maps them through the segment font
// and places the four patterns and the colon into the chain word.
// ----------------------------------------------------------------------------
module mmss_pack
(
    input  logic [1:0]     op,
    input  logic [6:0]     mins,
    input  logic [5:0]     secs,
    input  mmss_pkg::cfg_t cfg,
    output logic [31:0]    word
);

    logic [6:0]  pat [4];
    logic [13:0] hi;
    logic [15:0] lo;
    logic [15:0] colon_mask;
    logic        colon;

    // Clock digit patterns (3 = leftmost .. 0 = rightmost)
    always_comb
    begin
        colon = 1'b0;
        case (op)
            mmss_pkg::OP_TIME:
            begin
                pat[3] = mmss_pkg::font_digit(mmss_pkg::tens_of(mins));
                pat[2] = mmss_pkg::font_digit(mmss_pkg::units_of(mins));
                pat[1] = mmss_pkg::font_digit(mmss_pkg::tens_of({1'b0, secs}));
                pat[0] = mmss_pkg::font_digit(mmss_pkg::units_of({1'b0, secs}));
                colon  = 1'b1;
            end
            mmss_pkg::OP_DONE:
            begin
                pat[3] = mmss_pkg::GLYPH_LOWER_D;
                pat[2] = mmss_pkg::GLYPH_UPPER_O;
                pat[1] = mmss_pkg::GLYPH_LOWER_N;
                pat[0] = mmss_pkg::GLYPH_UPPER_E;
            end
            default:
            begin
                // blank, and the unused code
                pat[3] = 7'h00;
                pat[2] = 7'h00;
                pat[1] = 7'h00;
                pat[0] = 7'h00;
            end
        endcase
    end

    // Slot mapping onto the two boards, colon ORed into the second board
    assign colon_mask = colon ? (16'd1 << cfg.colon_pos) : 16'd0;
    assign hi   = {pat[cfg.slot_a_high], pat[cfg.slot_a_low]};
    assign lo   = {2'b00, pat[cfg.slot_b_high], pat[cfg.slot_b_low]} | colon_mask;
    assign word = {2'b00, hi, lo};

endmodule

// ===== rtl/mmss_seven_segment_frame_builder_top.sv =====
// ----------------------------------------------------------------------------
// mmss_seven_segment_frame_builder_top
// Builds one 32-bit two-board chain word per command and flags repeats of
// the last word sent.
// ----------------------------------------------------------------------------
// Sequence: a time command runs two passes of the bit-serial divider (minutes,
// then seconds) and then the pack step; blank and dOnE go straight to the pack
// step. One command is in work at a time: a new one is accepted only in idle.
// A full output register that is not taken stalls the pack step. Reset is
// asynchronous, active low: control and configuration registers return to
// defaults, the word cache becomes invalid.
// ----------------------------------------------------------------------------
module mmss_seven_segment_frame_builder_top
(
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] elapsed_ms
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] frame_word
    output logic        m_tuser,   // [0] send
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MIN  = 4'b0010,
        ST_SEC  = 4'b0100,
        ST_PACK = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    mmss_pkg::cfg_t cfg_reg,   cfg_next;
    logic [1:0]     op_reg,    op_next;
    logic [6:0]     mins_reg,  mins_next;
    logic [5:0]     secs_reg,  secs_next;
    logic [31:0]    last_word_reg,  last_word_next;
    logic           last_valid_reg, last_valid_next;
    logic           out_valid_reg,  out_valid_next;
    logic [31:0]    out_word_reg,   out_word_next;
    logic           out_send_reg,   out_send_next;

    logic        in_accept;
    logic        out_free;
    logic        send;
    logic [31:0] word;
    logic        div_start;
    logic [31:0] div_dividend;
    logic [15:0] div_divisor;
    logic        div_busy;
    logic        div_done;
    logic [31:0] div_quotient;
    logic [15:0] div_remainder;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // Shared serial divider: ms / 60000, then remainder / 1000
    mmss_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Digit font and slot mapping
    mmss_pack u_pack
    (
        .op   (op_reg),
        .mins (mins_reg),
        .secs (secs_reg),
        .cfg  (cfg_reg),
        .word (word)
    );

    assign send = !(last_valid_reg && (last_word_reg == word));

    // Configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mmss_pkg::CFG_SLOT_A_HIGH: cfg_next.slot_a_high = cfg_data[1:0];
                mmss_pkg::CFG_SLOT_A_LOW:  cfg_next.slot_a_low  = cfg_data[1:0];
                mmss_pkg::CFG_SLOT_B_HIGH: cfg_next.slot_b_high = cfg_data[1:0];
                mmss_pkg::CFG_SLOT_B_LOW:  cfg_next.slot_b_low  = cfg_data[1:0];
                mmss_pkg::CFG_COLON_POS:   cfg_next.colon_pos   = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        mins_next       = mins_reg;
        secs_next       = secs_reg;
        last_word_next  = last_word_reg;
        last_valid_next = last_valid_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_word_next   = out_word_reg;
        out_send_next   = out_send_reg;
        div_start       = 1'b0;
        div_dividend    = s_tdata;
        div_divisor     = mmss_pkg::MS_PER_MIN;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next = s_tuser;
                    if (s_tuser == mmss_pkg::OP_TIME)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_MIN;
                    end
                    else
                    begin
                        state_next = ST_PACK;
                    end
                end
            end
            ST_MIN:
            begin
                if (div_done)
                begin
                    mins_next    = (div_quotient > mmss_pkg::MIN_CLAMP) ?
                                   7'd99 : div_quotient[6:0];
                    div_start    = 1'b1;
                    div_dividend = {16'd0, div_remainder};
                    div_divisor  = mmss_pkg::MS_PER_SEC;
                    state_next   = ST_SEC;
                end
            end
            ST_SEC:
            begin
                if (div_done)
                begin
                    secs_next  = div_quotient[5:0];
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = word;
                    out_send_next  = send;
                    if (send)
                    begin
                        last_word_next  = word;
                        last_valid_next = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            cfg_reg.slot_a_high <= 2'd3;
            cfg_reg.slot_a_low  <= 2'd2;
            cfg_reg.slot_b_high <= 2'd1;
            cfg_reg.slot_b_low  <= 2'd0;
            cfg_reg.colon_pos   <= 4'd14;
            last_word_reg       <= 32'd0;
            last_valid_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_reg        <= cfg_next;
            last_word_reg  <= last_word_next;
            last_valid_reg <= last_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        mins_reg     <= mins_next;
        secs_reg     <= secs_next;
        out_word_reg <= out_word_next;
        out_send_reg <= out_send_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;
    assign m_tuser  = out_send_reg;

    // Divider never runs while the block waits for a command
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    // Packed time fields are in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PACK && op_reg == mmss_pkg::OP_TIME) |->
        (mins_reg <= 7'd99 && secs_reg <= 6'd59))
        else $error("minutes or seconds out of range");

    // A pending result flagged not to send matches the valid cache
    a_repeat_cached: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_send_reg) |->
        (last_valid_reg && last_word_reg == out_word_reg))
        else $error("repeat result does not match cache");

    // Any delivered result leaves the cache valid
    a_cache_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PACK && out_free) |=> last_valid_reg)
        else $error("cache invalid after result");

endmodule

// ===== test/mmss_seven_segment_frame_builder_top_test.sv =====
// ----------------------------------------------------------------------------
// mmss_seven_segment_frame_builder_top_test
// Self-checking bench for the MM:SS frame builder. Commands go in on the
// input stream, and each one's chain word and send flag are predicted from
// a local model of the digit split, font, slot layout, colon and word cache.
// The results are then compared in order. Directed cases cover the time
// extremes, the minute clamp, every command, repeats and the slot and colon
// extremes. Random traffic follows, with bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module mmss_seven_segment_frame_builder_top_test;

    // Spare command code, expected to behave as blank
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_ITEMS    = 155;

    typedef struct packed {
        logic [31:0] word;
        logic        send;
    } frame_t;

    typedef enum logic [1:0] {
        SINK_STEADY,
        SINK_COIN,
        SINK_LONG_STALLS,
        SINK_MOSTLY_READY
    } sink_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = mmss_pkg::OP_BLANK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = mmss_pkg::CFG_SLOT_A_HIGH;
    logic [3:0]  cfg_data = '0;

    // Predictor state: register shadow and word cache
    mmss_pkg::cfg_t layout = '{slot_a_high: 2'd3, slot_a_low: 2'd2,
                               slot_b_high: 2'd1, slot_b_low: 2'd0,
                               colon_pos: 4'd14};
    logic [31:0] cached_word = '0;
    logic        cached_valid = 1'b0;

    frame_t      frames_due[$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    logic [31:0] last_elapsed = '0;

    mmss_seven_segment_frame_builder_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Segment pattern of one decimal digit, bit0 = A .. bit6 = G
    function automatic logic [6:0] digit_segments(input logic [31:0] d);
        logic [6:0] seg;
        case (d)
            0:       seg = 7'h3F;
            1:       seg = 7'h06;
            2:       seg = 7'h5B;
            3:       seg = 7'h4F;
            4:       seg = 7'h66;
            5:       seg = 7'h6D;
            6:       seg = 7'h7D;
            7:       seg = 7'h07;
            8:       seg = 7'h7F;
            default: seg = 7'h6F;
        endcase
        return seg;
    endfunction

    // Chain word for one command under the current layout
    function automatic logic [31:0] build_frame_word(input logic [1:0] op,
                                                     input logic [31:0] elapsed);
        logic [6:0]  glyph [4];
        logic [31:0] whole_secs;
        logic [31:0] minutes;
        logic [31:0] seconds;
        logic [15:0] board_a;
        logic [15:0] board_b;
        logic        colon_on;
        for (int i = 0; i < 4; i++)
            glyph[i] = '0;
        colon_on = 1'b0;
        if (op == mmss_pkg::OP_TIME)
        begin
            whole_secs = elapsed / 1000;
            minutes    = whole_secs / 60;
            seconds    = whole_secs % 60;
            if (minutes > 99)
                minutes = 99;
            glyph[3] = digit_segments(minutes / 10);
            glyph[2] = digit_segments(minutes % 10);
            glyph[1] = digit_segments(seconds / 10);
            glyph[0] = digit_segments(seconds % 10);
            colon_on = 1'b1;
        end
        else if (op == mmss_pkg::OP_DONE)
        begin
            glyph[3] = mmss_pkg::GLYPH_LOWER_D;
            glyph[2] = mmss_pkg::GLYPH_UPPER_O;
            glyph[1] = mmss_pkg::GLYPH_LOWER_N;
            glyph[0] = mmss_pkg::GLYPH_UPPER_E;
        end
        board_a = {2'b00, glyph[layout.slot_a_high], glyph[layout.slot_a_low]};
        board_b = {2'b00, glyph[layout.slot_b_high], glyph[layout.slot_b_low]};
        // colon may land on any bit of the second board, ORed over segments
        if (colon_on)
            board_b[layout.colon_pos] = 1'b1;
        return {board_a, board_b};
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        if (mismatch_count < 10)
            $display("mismatch %0s at %0t: expected %h, got %h",
                     what, $realtime, exp_val, act_val);
        mismatch_count++;
    endtask

    // Shadow register writes, predict accepted items, check results
    always @(posedge clk)
    begin : frame_check
        frame_t      due;
        logic [31:0] word;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mmss_pkg::CFG_SLOT_A_HIGH: layout.slot_a_high = cfg_data[1:0];
                    mmss_pkg::CFG_SLOT_A_LOW:  layout.slot_a_low  = cfg_data[1:0];
                    mmss_pkg::CFG_SLOT_B_HIGH: layout.slot_b_high = cfg_data[1:0];
                    mmss_pkg::CFG_SLOT_B_LOW:  layout.slot_b_low  = cfg_data[1:0];
                    mmss_pkg::CFG_COLON_POS:   layout.colon_pos   = cfg_data;
                    default:                   ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                word = build_frame_word(s_tuser, s_tdata);
                due.word = word;
                due.send = !(cached_valid && cached_word == word);
                if (due.send)
                begin
                    cached_word  = word;
                    cached_valid = 1'b1;
                end
                frames_due.push_back(due);
            end
            if (m_tvalid && m_tready)
            begin
                if (frames_due.size() == 0)
                    note_mismatch("unexpected result", '0, m_tdata);
                else
                begin
                    due = frames_due.pop_front();
                    if (m_tdata !== due.word)
                        note_mismatch("frame_word", due.word, m_tdata);
                    if (m_tuser !== due.send)
                        note_mismatch("send", 32'(due.send), 32'(m_tuser));
                end
            end
        end
    end

    // Sink stalls: the ready pattern follows a mode that is re-drawn at random
    always @(posedge clk)
    begin : sink_pattern
        sink_mode_t mode;
        int         mode_left;
        int         hold_left;
        if (mode_left == 0)
        begin
            mode      = sink_mode_t'($urandom_range(0, 3));
            mode_left = $urandom_range(200, 900);
        end
        else
            mode_left--;
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
        begin
            case (mode)
                SINK_STEADY:
                    m_tready <= 1'b1;
                SINK_COIN:
                    m_tready <= 1'($urandom_range(0, 1));
                SINK_LONG_STALLS:
                begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        hold_left = $urandom_range(10, 60);
                end
                default:
                    m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("mmss_seven_segment_frame_builder_top verification failed");
            $finish;
        end
    end

    // Present one item and hold it until taken; valid stays high afterwards
    task automatic send_item(input logic [1:0] op, input logic [31:0] elapsed);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= elapsed;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (frames_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Whole register set in one back-to-back burst; slot upper bits are junk
    task automatic apply_layout(input logic [1:0] a_high, input logic [1:0] a_low,
                                input logic [1:0] b_high, input logic [1:0] b_low,
                                input logic [3:0] colon);
        write_reg(mmss_pkg::CFG_SLOT_A_HIGH, {2'($urandom), a_high});
        write_reg(mmss_pkg::CFG_SLOT_A_LOW, {2'($urandom), a_low});
        write_reg(mmss_pkg::CFG_SLOT_B_HIGH, {2'($urandom), b_high});
        write_reg(mmss_pkg::CFG_SLOT_B_LOW, {2'($urandom), b_low});
        write_reg(mmss_pkg::CFG_COLON_POS, colon);
        // index beyond the register set must be ignored
        write_reg(mmss_pkg::CFG_COLON_POS + 3'($urandom_range(1, 3)), 4'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Time extremes, minute clamp, every command and cache repeats
    task automatic test_time_extremes();
        send_item(mmss_pkg::OP_TIME, 32'd0);
        send_item(mmss_pkg::OP_TIME, 32'd0);            // repeat: no send
        send_item(mmss_pkg::OP_TIME, 32'd999);          // same display, no send
        send_item(mmss_pkg::OP_TIME, 32'd1000);
        send_item(mmss_pkg::OP_TIME, 32'd59999);
        send_item(mmss_pkg::OP_TIME, 32'd60000);
        send_item(mmss_pkg::OP_TIME, 32'd5999999);      // 99:59
        send_item(mmss_pkg::OP_TIME, 32'd6000000);      // clamps to 99:00
        send_item(mmss_pkg::OP_TIME, 32'hFFFF_FFFF);
        send_item(mmss_pkg::OP_BLANK, 32'hFFFF_FFFF);
        send_item(OP_SPARE, 32'h5A5A_A5A5);             // spare code acts as blank
        send_item(mmss_pkg::OP_DONE, 32'd0);
        send_item(mmss_pkg::OP_DONE, 32'h1234_5678);
        send_item(mmss_pkg::OP_TIME, 32'd0);
        s_tvalid <= 1'b0;
        wait_idle();
    endtask

    // Slot and colon extremes, ending back on the reset layout
    task automatic test_slot_layouts();
        logic [1:0] slots [5][4];
        logic [3:0] colons [5];
        slots[0] = '{2'd0, 2'd0, 2'd0, 2'd0};  colons[0] = 4'd0;
        slots[1] = '{2'd3, 2'd3, 2'd3, 2'd3};  colons[1] = 4'd15;
        slots[2] = '{2'd0, 2'd1, 2'd2, 2'd3};  colons[2] = 4'd7;
        slots[3] = '{2'd2, 2'd3, 2'd0, 2'd1};  colons[3] = 4'd13;
        slots[4] = '{2'd3, 2'd2, 2'd1, 2'd0};  colons[4] = 4'd14;
        for (int k = 0; k < 5; k++)
        begin
            apply_layout(slots[k][0], slots[k][1], slots[k][2], slots[k][3], colons[k]);
            send_item(mmss_pkg::OP_TIME, $urandom_range(0, 6_100_000));
            send_item(mmss_pkg::OP_DONE, $urandom);
            s_tvalid <= 1'b0;
            wait_idle();
        end
    endtask

    function automatic logic [1:0] pick_op();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll <= 6)
            return mmss_pkg::OP_TIME;
        else if (roll == 7)
            return mmss_pkg::OP_BLANK;
        else if (roll == 8)
            return mmss_pkg::OP_DONE;
        return OP_SPARE;
    endfunction

    // Mix of full-range, display-range, boundary and near-repeat times
    function automatic logic [31:0] pick_elapsed(input logic [31:0] prev);
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2, 3, 4: return $urandom_range(0, 6_100_000);
            5:       return $urandom_range(0, 6100) * 1000 - $urandom_range(0, 1);
            6:       return $urandom_range(95, 105) * 60000 + $urandom_range(0, 59999);
            7, 8:    return prev + $urandom_range(0, 999);
            default: return prev;
        endcase
    endfunction

    // Phases of random commands, each under a fresh random layout
    task automatic test_random_traffic();
        int         burst_left;
        logic       gappy;
        logic [1:0] op;
        logic [3:0] colon;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            colon = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(14, 15))
                                                : 4'($urandom);
            apply_layout(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom), colon);
            gappy      = ($urandom_range(0, 3) != 0);
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (gappy && burst_left == 0)
                begin
                    pause_sender($urandom_range(1, 150));
                    burst_left = $urandom_range(1, 20);
                end
                op = pick_op();
                last_elapsed = pick_elapsed(last_elapsed);
                send_item(op, last_elapsed);
                if (burst_left != 0)
                    burst_left--;
            end
            s_tvalid <= 1'b0;
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_time_extremes();
        test_slot_layouts();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && frames_due.size() == 0)
            $display("mmss_seven_segment_frame_builder_top verification clean");
        else
            $display("mmss_seven_segment_frame_builder_top verification failed");
        $finish;
    end

endmodule
